>>> hdl/srjb_pkg.sv
`timescale 1ns / 1ps
package srjb_pkg;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_LATE     = 3'd1,
    ST_DUP      = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_DEQUEUED = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_FLUSHED  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_SCAN,
    FS_PLAN,
    FS_SHIFT,
    FS_WRITE,
    FS_DONE
  } fsm_e;

  localparam int unsigned CfgIdxBits = 1;
  localparam int unsigned CfgBits    = 5;
  localparam logic [CfgIdxBits-1:0] CFG_DEPTH_LIMIT = 1'd0;
  localparam logic [CfgIdxBits-1:0] CFG_PREROLL     = 1'd1;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] seq;
    logic [15:0] payload_handle;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_seq;
    logic [15:0] out_handle;
    logic        evict_valid;
    logic [15:0] evict_seq;
    logic [15:0] evict_handle;
    logic [4:0]  queue_count;
    logic        preroll_met;
  } rsp_t;

endpackage

>>> hdl/sequence_reorder_jitter_buffer.sv
`timescale 1ns / 1ps
// Sequence-ordered jitter buffer. Pulse start with a request while busy is
// low; exactly one result appears on rsp_o with done_o high for one cycle and
// cannot be stalled. Entries live in a single-port-read memory kept oldest at
// slot 0 (head pointer based ring). An enqueue scans from the newest entry down,
// one memory read per cycle, then shifts younger entries up one slot at a time,
// reading each entry and then writing it one slot higher. A dequeue passes
// through the scan and done states; a flush, a late drop and the unused opcode
// go straight to the done state. No clearing pass follows reset.
module sequence_reorder_jitter_buffer
  import srjb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CfgBits-1:0]    cfg_data_i,
  output logic                  done_o,
  output rsp_t                  rsp_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // ring memory, logical slot k at head + k
  logic [31:0] mem_q [QUEUE_DEPTH];
  logic [31:0] rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [31:0]   wr_data;

  fsm_e state_q, state_d;
  req_t req_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] pos_q, pos_d;     // insertion slot
  logic [CW-1:0] k_q, k_d;         // scan / shift cursor
  logic          rdp_q, rdp_d;     // read phase during shift
  logic [15:0]   last_q, last_d;
  logic          played_q, played_d;
  logic [4:0]    lim_q, prer_q;
  rsp_t          rsp_q, rsp_d;
  logic          done_q;

  logic [CW-1:0] lim_eff;
  logic [15:0]   diff;
  logic          lim_hit;

  always_comb begin
    if (lim_q == 5'd0) lim_eff = CW'(1);
    else if (32'(lim_q) > QUEUE_DEPTH) lim_eff = CW'(QUEUE_DEPTH);
    else lim_eff = CW'(lim_q);
  end

  assign diff    = req_q.seq - rd_q[31:16];
  assign lim_hit = fill_q >= lim_eff;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(k);
    if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
    return s[AW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q  <= 5'd16;
      prer_q <= 5'd3;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_DEPTH_LIMIT) lim_q <= cfg_data_i;
      else lim_q <= lim_q;
      if (cfg_idx_i == CFG_PREROLL) prer_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FS_IDLE;
      head_q   <= '0;
      fill_q   <= '0;
      pos_q    <= '0;
      k_q      <= '0;
      rdp_q    <= 1'b0;
      last_q   <= '0;
      played_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      pos_q    <= pos_d;
      k_q      <= k_d;
      rdp_q    <= rdp_d;
      last_q   <= last_d;
      played_q <= played_d;
      done_q   <= (state_q == FS_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) req_q <= req_i;
    rsp_q <= rsp_d;
  end

  // next state and datapath
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    fill_d   = fill_q;
    pos_d    = pos_q;
    k_d      = k_q;
    rdp_d    = rdp_q;
    last_d   = last_q;
    played_d = played_q;
    rsp_d    = rsp_q;
    rd_addr  = slot(head_q, k_q);
    wr_en    = 1'b0;
    wr_addr  = slot(head_q, k_q);
    wr_data  = {req_q.seq, req_q.payload_handle};
    case (state_q)
      FS_IDLE: begin
        if (start) begin
          rsp_d = '0;
          rsp_d.status = ST_EMPTY;
          state_d = FS_SCAN;
          rd_addr = head_q;
          k_d = fill_q;
          pos_d = fill_q;
          // read newest entry for enqueue, oldest for dequeue
          if (req_i.op == OP_ENQ) begin
            rd_addr = slot(head_q, fill_q - CW'(1));
            if (played_q && (req_i.seq == last_q ||
                (req_i.seq - last_q) >= 16'h8000)) begin
              rsp_d.status = ST_LATE;
              state_d = FS_DONE;
            end
          end else if (req_i.op == OP_FLUSH) begin
            fill_d = '0;
            played_d = 1'b0;
            rsp_d.status = ST_FLUSHED;
            state_d = FS_DONE;
          end else if (req_i.op == OP_NONE) begin
            state_d = FS_DONE;
          end
        end
      end
      FS_SCAN: begin
        // rd_q holds slot k_q-1 (enqueue) or slot 0 (dequeue)
        if (req_q.op == OP_DEQ) begin
          if (fill_q != '0) begin
            rsp_d.status = ST_DEQUEUED;
            rsp_d.out_seq = rd_q[31:16];
            rsp_d.out_handle = rd_q[15:0];
            last_d = rd_q[31:16];
            played_d = 1'b1;
            head_d = slot(head_q, CW'(1));
            fill_d = fill_q - CW'(1);
          end
          state_d = FS_DONE;
        end else if (k_q == '0) begin
          state_d = FS_PLAN;
        end else if (diff == '0) begin
          rsp_d.status = ST_DUP;
          state_d = FS_DONE;
        end else if (!diff[15]) begin
          state_d = FS_PLAN;
        end else begin
          pos_d = k_q - CW'(1);
          k_d = k_q - CW'(1);
          rd_addr = slot(head_q, k_q - CW'(2));
        end
        if (state_d == FS_PLAN) rd_addr = head_q;
      end
      FS_PLAN: begin
        // rd_q holds the oldest entry
        state_d = FS_SHIFT;
        if (lim_hit) begin
          rsp_d.evict_valid = 1'b1;
          rsp_d.evict_seq = rd_q[31:16];
          rsp_d.evict_handle = rd_q[15:0];
          head_d = slot(head_q, CW'(1));
          fill_d = fill_q - CW'(1);
          if (pos_q == '0 || (fill_q - CW'(1)) >= lim_eff) begin
            rsp_d.status = ST_OVERFLOW;
            state_d = FS_DONE;
          end else begin
            pos_d = pos_q - CW'(1);
          end
        end
        k_d = lim_hit ? fill_q - CW'(1) : fill_q;
        rdp_d = 1'b1;
      end
      FS_SHIFT: begin
        // move slot k-1 to slot k, from the top down to pos
        if (k_q == pos_q) begin
          state_d = FS_WRITE;
        end else if (rdp_q) begin
          rd_addr = slot(head_q, k_q - CW'(1));
          rdp_d = 1'b0;
        end else begin
          wr_en = 1'b1;
          wr_addr = slot(head_q, k_q);
          wr_data = rd_q;
          k_d = k_q - CW'(1);
          rdp_d = 1'b1;
        end
      end
      FS_WRITE: begin
        wr_en = 1'b1;
        wr_addr = slot(head_q, pos_q);
        fill_d = fill_q + CW'(1);
        rsp_d.status = ST_INSERTED;
        state_d = FS_DONE;
      end
      FS_DONE: begin
        rsp_d.queue_count = 5'(fill_q);
        rsp_d.preroll_met = 5'(fill_q) >= prer_q;
        state_d = FS_IDLE;
      end
      default: state_d = FS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy   = (state_q != FS_IDLE);
    done_o = done_q;
    rsp_o  = rsp_q;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(QUEUE_DEPTH)) else $error("fill exceeds depth");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FS_SHIFT |-> (pos_q <= k_q)) else $error("shift cursor below slot");
  a_evict_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.evict_valid |-> (rsp_o.status == ST_INSERTED ||
    rsp_o.status == ST_OVERFLOW)) else $error("eviction on non-enqueue");

endmodule

>>> tb/tb_sequence_reorder_jitter_buffer_checker.sv
`timescale 1ns / 1ps
module tb_sequence_reorder_jitter_buffer_checker
  import srjb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  req_t                  req_i,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CfgBits-1:0]    cfg_data_i,
  input  logic                  done_i,
  input  rsp_t                  rsp_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    results_seen_o
);

  localparam int Depth = 16;

  logic [15:0] q_seq [Depth];
  logic [15:0] q_handle [Depth];
  int          q_fill;
  logic [15:0] played_seq;
  logic        played_any;
  logic [4:0]  limit_reg;
  logic [4:0]  preroll_reg;
  rsp_t        outcome_q [$];

  assign pending_o = outcome_q.size();

  // -1 when a precedes b, 0 when equal, +1 when a follows b
  function automatic int seq_cmp(logic [15:0] a, logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    if (d == 16'd0) return 0;
    return d[15] ? -1 : 1;
  endfunction

  function automatic int eff_limit();
    if (limit_reg < 1) return 1;
    if (limit_reg > Depth) return Depth;
    return limit_reg;
  endfunction

  task automatic pop_head(output logic [15:0] s, output logic [15:0] h);
    s = q_seq[0];
    h = q_handle[0];
    for (int k = 1; k < q_fill; k++) begin
      q_seq[k-1] = q_seq[k];
      q_handle[k-1] = q_handle[k];
    end
    q_fill--;
  endtask

  task automatic predict_outcome(req_t r);
    rsp_t o;
    int   pos;
    int   ord;
    logic drop;
    logic [15:0] s, h;
    o = '0;
    o.status = ST_EMPTY;
    if (r.op == OP_ENQ) begin
      pos = q_fill;
      drop = 1'b0;
      if (played_any && seq_cmp(r.seq, played_seq) <= 0) begin
        o.status = ST_LATE;
        drop = 1'b1;
      end
      while (!drop && pos > 0) begin
        ord = seq_cmp(r.seq, q_seq[pos-1]);
        if (ord == 0) begin
          o.status = ST_DUP;
          drop = 1'b1;
        end else if (ord > 0) begin
          break;
        end else begin
          pos--;
        end
      end
      if (!drop && q_fill >= eff_limit()) begin
        pop_head(s, h);
        o.evict_valid = 1'b1;
        o.evict_seq = s;
        o.evict_handle = h;
        if (pos == 0 || q_fill >= eff_limit()) begin
          o.status = ST_OVERFLOW;
          drop = 1'b1;
        end else begin
          pos--;
        end
      end
      if (!drop) begin
        for (int k = q_fill; k > pos; k--) begin
          q_seq[k] = q_seq[k-1];
          q_handle[k] = q_handle[k-1];
        end
        q_seq[pos] = r.seq;
        q_handle[pos] = r.payload_handle;
        q_fill++;
        o.status = ST_INSERTED;
      end
    end else if (r.op == OP_DEQ) begin
      if (q_fill != 0) begin
        pop_head(s, h);
        o.out_seq = s;
        o.out_handle = h;
        played_seq = s;
        played_any = 1'b1;
        o.status = ST_DEQUEUED;
      end
    end else if (r.op == OP_FLUSH) begin
      q_fill = 0;
      played_any = 1'b0;
      o.status = ST_FLUSHED;
    end
    o.queue_count = q_fill[4:0];
    o.preroll_met = (q_fill >= preroll_reg);
    outcome_q.push_back(o);
  endtask

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      q_fill = 0;
      played_seq = '0;
      played_any = 1'b0;
      limit_reg = 5'd16;
      preroll_reg = 5'd3;
      fail_count_o = 0;
      results_seen_o = 0;
      outcome_q.delete();
    end else begin
      if (done_i) begin
        results_seen_o++;
        if (outcome_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count_o++;
        end else begin
          e = outcome_q.pop_front();
          check_field("status", 16'(e.status), 16'(rsp_i.status));
          check_field("out_seq", e.out_seq, rsp_i.out_seq);
          check_field("out_handle", e.out_handle, rsp_i.out_handle);
          check_field("evict_valid", 16'(e.evict_valid), 16'(rsp_i.evict_valid));
          check_field("evict_seq", e.evict_seq, rsp_i.evict_seq);
          check_field("evict_handle", e.evict_handle, rsp_i.evict_handle);
          check_field("queue_count", 16'(e.queue_count), 16'(rsp_i.queue_count));
          check_field("preroll_met", 16'(e.preroll_met), 16'(rsp_i.preroll_met));
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_DEPTH_LIMIT) limit_reg = cfg_data_i;
        else if (cfg_idx_i == CFG_PREROLL) preroll_reg = cfg_data_i;
      end
      if (start_i && !busy_i) predict_outcome(req_i);
    end
  end

endmodule

>>> tb/tb_sequence_reorder_jitter_buffer.sv
`timescale 1ns / 1ps
module tb_sequence_reorder_jitter_buffer;
  import srjb_pkg::*;

  localparam int StallLimit = 5000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  req_t                  req_i;
  logic                  cfg_we_i;
  logic [CfgIdxBits-1:0] cfg_idx_i;
  logic [CfgBits-1:0]    cfg_data_i;
  logic                  done_o;
  rsp_t                  rsp_o;
  int                    fail_count;
  int                    pending;
  int                    results_seen;
  int                    requests_sent;
  int                    idle_cycles;
  logic                  calm;
  logic [15:0]           seq_base;

  sequence_reorder_jitter_buffer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start_i),
    .busy       (busy_o),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

  tb_sequence_reorder_jitter_buffer_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .req_i          (req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .done_i         (done_o),
    .rsp_i          (rsp_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_seen_o (results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Count cycles with nothing accepted; give up when the block hangs.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("sequence_reorder_jitter_buffer test failed");
        $finish;
      end
    end
  end

  task automatic send_request(op_e op, logic [15:0] s, logic [15:0] h);
    if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 19)) @(posedge clk_i);
    start_i <= 1'b1;
    req_i <= '{op: op, seq: s, payload_handle: h};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    start_i <= 1'b0;
    requests_sent++;
    // Hold start low for one cycle so busy can rise before the next request.
    @(posedge clk_i);
  endtask

  task automatic drain_block();
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgBits-1:0] val);
    drain_block();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int count);
    int   pick;
    logic [15:0] s;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // mostly near the play point, reordered; now and then far away
        if ($urandom_range(0, 9) == 0) s = 16'($urandom);
        else s = seq_base + 16'($urandom_range(0, 24)) - 16'd4;
        send_request(OP_ENQ, s, 16'($urandom));
      end else if (pick < 85) begin
        seq_base = seq_base + 16'd1;
        send_request(OP_DEQ, 16'($urandom), 16'($urandom));
      end else if (pick < 90) begin
        send_request(OP_FLUSH, 16'($urandom), 16'($urandom));
      end else if (pick < 93) begin
        send_request(OP_NONE, 16'($urandom), 16'($urandom));
      end else begin
        seq_base = seq_base + 16'($urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    requests_sent = 0;
    calm = 1'b0;
    seq_base = 16'hFFF0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty dequeue, wrap ordering, duplicate, late, unused op, flush
    send_request(OP_DEQ, 16'h0000, 16'h0000);
    send_request(OP_ENQ, 16'h0001, 16'hFFFF);
    send_request(OP_ENQ, 16'hFFFF, 16'h0000);
    send_request(OP_ENQ, 16'h8000, 16'hAAAA);
    send_request(OP_ENQ, 16'h0001, 16'h5555);
    send_request(OP_DEQ, 16'hFFFF, 16'hFFFF);
    send_request(OP_ENQ, 16'h8000, 16'h1234);
    send_request(OP_ENQ, 16'h7FFF, 16'h4321);
    send_request(OP_NONE, 16'hFFFF, 16'hFFFF);
    send_request(OP_FLUSH, 16'h0000, 16'h0000);
    send_request(OP_ENQ, 16'h8000, 16'h0F0F);
    // shrink the limit under the fill: evict one per enqueue
    for (int k = 0; k < 5; k++) send_request(OP_ENQ, 16'(k + 16'h10), 16'(k));
    write_reg(CFG_DEPTH_LIMIT, 5'd2);
    write_reg(CFG_PREROLL, 5'd0);
    send_request(OP_ENQ, 16'h0020, 16'h0001);
    send_request(OP_ENQ, 16'h0021, 16'h0002);
    send_request(OP_ENQ, 16'h0000, 16'h0003);
    write_reg(CFG_DEPTH_LIMIT, 5'd0);
    send_request(OP_ENQ, 16'h0030, 16'h0004);
    send_request(OP_ENQ, 16'h0002, 16'h0005);
    write_reg(CFG_DEPTH_LIMIT, 5'd31);
    write_reg(CFG_PREROLL, 5'd31);

    random_phase(200);
    write_reg(CFG_DEPTH_LIMIT, 5'd16);
    write_reg(CFG_PREROLL, 5'd16);
    random_phase(200);
    write_reg(CFG_DEPTH_LIMIT, 5'd1);
    write_reg(CFG_PREROLL, 5'd1);
    random_phase(150);
    write_reg(CFG_DEPTH_LIMIT, 5'($urandom_range(2, 15)));
    write_reg(CFG_PREROLL, 5'($urandom_range(0, 17)));
    random_phase(150);
    calm = 1'b1;
    random_phase(150);

    drain_block();
    $display("covered %0d requests and %0d results across several depth and preroll limits",
             requests_sent, results_seen);
    if (fail_count == 0) begin
      $display("sequence_reorder_jitter_buffer test passed");
    end else begin
      $display("sequence_reorder_jitter_buffer test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/srjb_pkg.sv
hdl/sequence_reorder_jitter_buffer.sv
tb/tb_sequence_reorder_jitter_buffer_checker.sv
tb/tb_sequence_reorder_jitter_buffer.sv
